// ===== hw/rtl/cmre_pkg.sv =====
// ----------------------------------------------------------------------------
// cmre_pkg
// Shared types and constants of the counted mutex request engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cmre_pkg;

  localparam int unsigned ID_W     = 4;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned AMOUNT_W = 4;
  localparam int unsigned PERMIT_W = 4;
  localparam int unsigned STOCK_W  = 16;
  localparam int unsigned CFG_W    = 4;

  localparam logic CFG_NODE_ID    = 1'b0;
  localparam logic CFG_PEER_COUNT = 1'b1;

  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_AGREE   = 2'd2;
  localparam logic [1:0] KIND_INCR    = 2'd3;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_COMP = 2'd1;
  localparam logic [1:0] MODE_ACQ  = 2'd2;

  localparam logic [2:0] FUNC_ACQUIRE   = 3'd0;
  localparam logic [2:0] FUNC_RELEASE   = 3'd1;
  localparam logic [2:0] FUNC_REQUEST   = 3'd2;
  localparam logic [2:0] FUNC_AGREE     = 3'd3;
  localparam logic [2:0] FUNC_INCREMENT = 3'd4;
  localparam logic [2:0] FUNC_PRODUCE   = 3'd5;

  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_ACQUIRE   = 3'd1,
    OP_RELEASE   = 3'd2,
    OP_REQUEST   = 3'd3,
    OP_AGREE     = 3'd4,
    OP_INCREMENT = 3'd5,
    OP_PRODUCE   = 3'd6
  } op_e;

  typedef struct packed {
    logic [2:0]          func;
    logic [STAMP_W-1:0]  stamp;
    logic [ID_W-1:0]     sender;
    logic                consumed;
    logic [AMOUNT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                 kind;
    logic [ID_W-1:0]            dest;
    logic                       agree_consumed;
    logic [AMOUNT_W-1:0]        sent_amount;
    logic [STAMP_W-1:0]         sent_stamp;
    logic [1:0]                 node_state;
    logic signed [STOCK_W-1:0]  resources;
    logic                       overflow;
    logic                       last;
  } out_item_t;

  typedef struct packed {
    op_e                 op;
    logic [STAMP_W-1:0]  stamp;
    logic [ID_W-1:0]     sender;
    logic                consumed;
    logic [AMOUNT_W-1:0] amount;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cmre_ram.sv =====
// ----------------------------------------------------------------------------
// cmre_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cmre_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 15,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [ADDR_W-1:0]   waddr_i,
  input  wire logic [WIDTH-1:0]    wdata_i,
  input  wire logic                re_i,
  input  wire logic [ADDR_W-1:0]   raddr_i,
  output logic      [WIDTH-1:0]    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cmre_front.sv =====
// ----------------------------------------------------------------------------
// cmre_front
// Accepts input transactions, decodes the function code and holds the
// decoded commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cmre_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire cmre_pkg::in_item_t in_data_i,
  output logic                   cmd_valid_o,
  output cmre_pkg::cmd_t         cmd_o,
  input  wire logic              cmd_pop_i
);

  cmre_pkg::cmd_t entry_q [2];
  cmre_pkg::cmd_t dec;
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  logic           push;

  always_comb begin
    dec.stamp    = in_data_i.stamp;
    dec.sender   = in_data_i.sender;
    dec.consumed = in_data_i.consumed;
    dec.amount   = in_data_i.amount;
    case (in_data_i.func)
      cmre_pkg::FUNC_ACQUIRE:   dec.op = cmre_pkg::OP_ACQUIRE;
      cmre_pkg::FUNC_RELEASE:   dec.op = cmre_pkg::OP_RELEASE;
      cmre_pkg::FUNC_REQUEST:   dec.op = cmre_pkg::OP_REQUEST;
      cmre_pkg::FUNC_AGREE:     dec.op = cmre_pkg::OP_AGREE;
      cmre_pkg::FUNC_INCREMENT: dec.op = cmre_pkg::OP_INCREMENT;
      cmre_pkg::FUNC_PRODUCE:   dec.op = cmre_pkg::OP_PRODUCE;
      default:                  dec.op = cmre_pkg::OP_NONE;
    endcase
  end

  assign in_stall_o  = (count_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cmre_back.sv =====
// ----------------------------------------------------------------------------
// cmre_back
// Carries out decoded commands: node mode, permits, resource count and the
// deferred requester queue, and drives the registered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module cmre_back #(
  parameter int unsigned MAX_NODES = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [cmre_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  wire logic                        cmd_valid_i,
  input  wire cmre_pkg::cmd_t              cmd_i,
  output logic                             cmd_pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output cmre_pkg::out_item_t              out_data_o
);

  localparam int unsigned QCAP   = MAX_NODES - 1;
  localparam int unsigned ADDR_W = (QCAP > 1) ? $clog2(QCAP) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_NODES);

  typedef enum logic [1:0] {
    B_RUN  = 2'b01,
    B_WALK = 2'b10
  } bstate_e;

  function automatic logic signed [cmre_pkg::STOCK_W-1:0] sat_add(
    input logic signed [cmre_pkg::STOCK_W-1:0] s,
    input logic signed [5:0]                   d
  );
    logic signed [cmre_pkg::STOCK_W:0] sum;
    sum = $signed({s[cmre_pkg::STOCK_W-1], s}) + $signed({{11{d[5]}}, d});
    if (sum > $signed(17'h07FFF)) begin
      return 16'sh7FFF;
    end else if (sum < $signed(17'h18000)) begin
      return 16'sh8000;
    end
    return sum[cmre_pkg::STOCK_W-1:0];
  endfunction

  bstate_e                                state_q, state_d;
  logic [1:0]                             mode_q, mode_d;
  logic [cmre_pkg::PERMIT_W-1:0]          permit_q, permit_d;
  logic [cmre_pkg::STAMP_W-1:0]           own_stamp_q, own_stamp_d;
  logic signed [cmre_pkg::STOCK_W-1:0]    stock_q, stock_d;
  logic [CNT_W-1:0]                       dcount_q, dcount_d;
  logic [CNT_W-1:0]                       walk_cnt_q, walk_cnt_d;
  logic [ADDR_W-1:0]                      idx_q, idx_d;
  logic [cmre_pkg::ID_W-1:0]              node_id_q;
  logic [cmre_pkg::PERMIT_W-1:0]          peer_count_q;
  logic                                   out_valid_q;
  cmre_pkg::out_item_t                    out_q, res;
  logic                                   out_free, push;
  logic                                   ram_we, ram_re;
  logic [ADDR_W-1:0]                      ram_raddr;
  logic [cmre_pkg::ID_W-1:0]              ram_rdata;
  logic                                   defer, walk_last;
  logic signed [5:0]                      delta;

  assign out_free = !out_valid_q || !out_stall_i;
  assign walk_last = (CNT_W'(idx_q) + CNT_W'(1)) == walk_cnt_q;

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    permit_d    = permit_q;
    own_stamp_d = own_stamp_q;
    stock_d     = stock_q;
    dcount_d    = dcount_q;
    walk_cnt_d  = walk_cnt_q;
    idx_d       = idx_q;
    res         = '0;
    push        = 1'b0;
    cmd_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = idx_q;
    delta       = '0;
    defer       = 1'b0;
    case (state_q)
      B_RUN: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          push      = 1'b1;
          case (cmd_i.op)
            cmre_pkg::OP_ACQUIRE: begin
              mode_d         = cmre_pkg::MODE_COMP;
              permit_d       = '0;
              own_stamp_d    = cmd_i.stamp;
              res.kind       = cmre_pkg::KIND_REQUEST;
              res.sent_stamp = cmd_i.stamp;
            end
            cmre_pkg::OP_RELEASE: begin
              mode_d  = cmre_pkg::MODE_IDLE;
              stock_d = sat_add(stock_q, 6'sh3F);
              if (dcount_q != '0) begin
                push       = 1'b0;
                ram_re     = 1'b1;
                ram_raddr  = '0;
                idx_d      = '0;
                walk_cnt_d = dcount_q;
                dcount_d   = '0;
                state_d    = B_WALK;
              end
            end
            cmre_pkg::OP_REQUEST: begin
              if (mode_q == cmre_pkg::MODE_ACQ) begin
                defer = 1'b1;
              end else if (mode_q == cmre_pkg::MODE_COMP) begin
                defer = (cmd_i.stamp > own_stamp_q) ||
                        ((cmd_i.stamp == own_stamp_q) && (cmd_i.sender > node_id_q));
              end
              if (defer) begin
                if (dcount_q < CNT_W'(QCAP)) begin
                  ram_we   = 1'b1;
                  dcount_d = dcount_q + CNT_W'(1);
                end else begin
                  res.overflow = 1'b1;
                end
              end else begin
                res.kind = cmre_pkg::KIND_AGREE;
                res.dest = cmd_i.sender;
              end
            end
            cmre_pkg::OP_AGREE: begin
              if (mode_q == cmre_pkg::MODE_COMP) begin
                delta   = cmd_i.consumed ? 6'sh3F : 6'sh00;
                stock_d = sat_add(stock_q, delta);
                if (permit_q != '1) begin
                  permit_d = permit_q + cmre_pkg::PERMIT_W'(1);
                end
              end
            end
            cmre_pkg::OP_INCREMENT: begin
              delta   = $signed({2'b00, cmd_i.amount});
              stock_d = sat_add(stock_q, delta);
            end
            cmre_pkg::OP_PRODUCE: begin
              delta           = $signed({2'b00, cmd_i.amount});
              stock_d         = sat_add(stock_q, delta);
              res.kind        = cmre_pkg::KIND_INCR;
              res.sent_amount = cmd_i.amount;
              res.sent_stamp  = own_stamp_q;
            end
            default: begin
            end
          endcase
          if ((cmd_i.op == cmre_pkg::OP_AGREE || cmd_i.op == cmre_pkg::OP_INCREMENT ||
               cmd_i.op == cmre_pkg::OP_PRODUCE) &&
              mode_d == cmre_pkg::MODE_COMP && permit_d == peer_count_q &&
              stock_d > $signed(16'sh0000)) begin
            mode_d = cmre_pkg::MODE_ACQ;
          end
          res.node_state = mode_d;
          res.resources  = stock_d;
          res.last       = 1'b1;
        end
      end
      B_WALK: begin
        if (out_free) begin
          push               = 1'b1;
          res.kind           = cmre_pkg::KIND_AGREE;
          res.dest           = ram_rdata;
          res.agree_consumed = 1'b1;
          res.node_state     = mode_q;
          res.resources      = stock_q;
          res.last           = walk_last;
          if (walk_last) begin
            state_d = B_RUN;
          end else begin
            idx_d     = idx_q + ADDR_W'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_q + ADDR_W'(1);
          end
        end
      end
      default: begin
        state_d = B_RUN;
      end
    endcase
  end

  cmre_ram #(
    .WIDTH (cmre_pkg::ID_W),
    .DEPTH (QCAP)
  ) u_deferred (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (dcount_q[ADDR_W-1:0]),
    .wdata_i (cmd_i.sender),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q <= res;
    end
    walk_cnt_q  <= walk_cnt_d;
    idx_q       <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_RUN;
      mode_q       <= cmre_pkg::MODE_IDLE;
      permit_q     <= '0;
      own_stamp_q  <= '0;
      stock_q      <= '0;
      dcount_q     <= '0;
      out_valid_q  <= 1'b0;
      node_id_q    <= '0;
      peer_count_q <= cmre_pkg::PERMIT_W'(1);
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      permit_q    <= permit_d;
      own_stamp_q <= own_stamp_d;
      stock_q     <= stock_d;
      dcount_q    <= dcount_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cmre_pkg::CFG_NODE_ID:    node_id_q    <= cfg_wdata_i;
          cmre_pkg::CFG_PEER_COUNT: peer_count_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_walk_empties_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_WALK |-> dcount_q == '0)
    else $error("deferred count not cleared during release walk");

  a_no_pop_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_WALK |-> !cmd_pop_o)
    else $error("command taken while release walk is running");

  a_partial_only_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.last |-> state_q == B_WALK)
    else $error("non-final result held outside release walk");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcount_q <= CNT_W'(QCAP))
    else $error("deferred count beyond queue capacity");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_WALK |-> (CNT_W'(idx_q) < walk_cnt_q))
    else $error("release walk index beyond queued entries");

endmodule

`default_nettype wire

// ===== hw/rtl/counted_mutex_request_engine.sv =====
// ----------------------------------------------------------------------------
// counted_mutex_request_engine
// One node of timestamp-ordered mutual exclusion over a counted resource.
//
// Input transactions carry local events and received protocol messages on
// in_valid_i/in_stall_o; results leave on out_valid_o/out_stall_i. A
// transaction is taken when valid is high and stall is low.
// A two-entry command queue sits in front of the execution unit, so input is
// taken while results wait. A result is loaded into the output register when
// the execution unit takes its command from the queue. Most inputs yield one
// result and the engine takes one per cycle while the output is free.
// A release with N deferred requesters yields N agreements, one per cycle
// while the output is free, read through the registered deferred-id RAM; no
// command enters execution until the last of them is in the output register.
// A stalled receiver holds the output register; execution waits and the
// command queue fills, then in_stall_o rises.
// Reset empties the queues, returns the node to idle with no permits and no
// stock, and sets node_id to 0 and peer_count to 1. The cfg port writes a
// register at each clock edge with cfg_we_i high.
// ----------------------------------------------------------------------------
`default_nettype none

module counted_mutex_request_engine #(
  parameter int unsigned MAX_NODES = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire cmre_pkg::in_item_t          in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output cmre_pkg::out_item_t              out_data_o,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [cmre_pkg::CFG_W-1:0]  cfg_wdata_i
);

  logic           cmd_valid;
  logic           cmd_pop;
  cmre_pkg::cmd_t cmd;

  cmre_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  cmre_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== sim/tb_counted_mutex_request_engine.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_counted_mutex_request_engine
// Self-checking bench for one node of timestamp-ordered mutual exclusion.
//
// A driver feeds local events and protocol messages from a queue, and a
// monitor checks every output transaction against a cycle-free predictor of
// the node that tracks mode, permits, request stamp, stock and deferred
// senders. A short directed sequence covers the tie rules and the quiet
// opcodes. Then random acquire/release rounds run under several register
// settings and backpressure mixes.
// ----------------------------------------------------------------------------
module tb_counted_mutex_request_engine;

  typedef logic [2:0]                    func_t;
  typedef logic [cmre_pkg::ID_W-1:0]     id_t;
  typedef logic [cmre_pkg::PERMIT_W-1:0] permit_t;
  typedef logic [cmre_pkg::STAMP_W-1:0]  stamp_t;
  typedef logic [cmre_pkg::AMOUNT_W-1:0] amount_t;

  localparam int    WATCHDOG_LIMIT = 4000;
  localparam int    SETTLE_CYCLES  = 20;
  localparam int    RANDOM_ITEMS   = 60;
  localparam int    QUEUE_DEPTH    = 15;
  localparam int    STOCK_TOP      = 32767;
  localparam int    STOCK_BOTTOM   = -32768;
  localparam int    MAX_PRINTS     = 200;
  localparam func_t FUNC_SPARE_LO  = 3'd6;
  localparam func_t FUNC_SPARE_HI  = 3'd7;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  cmre_pkg::in_item_t             in_data;
  logic                           out_valid;
  logic                           out_stall;
  cmre_pkg::out_item_t            out_data;
  logic                           cfg_we;
  logic                           cfg_idx;
  logic [cmre_pkg::CFG_W-1:0]     cfg_wdata;

  cmre_pkg::in_item_t  inbound[$];
  cmre_pkg::out_item_t due_msgs[$];
  int                  queued_count;
  int                  taken_count;
  int                  mismatches;
  int                  quiet_cycles;
  int                  send_gap_pct;
  int                  recv_gap_pct;
  logic                in_taken;

  id_t        my_id;
  permit_t    peers;
  logic [1:0] node_mode;
  permit_t    permits;
  stamp_t     my_stamp;
  int         stock_level;
  id_t        waiting_ids [QUEUE_DEPTH];
  int         waiting_count;

  counted_mutex_request_engine DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int sat_stock(input int v);
    if (v > STOCK_TOP) return STOCK_TOP;
    if (v < STOCK_BOTTOM) return STOCK_BOTTOM;
    return v;
  endfunction

  function automatic void check_grant();
    if (node_mode == cmre_pkg::MODE_COMP && permits == peers && stock_level > 0) begin
      node_mode = cmre_pkg::MODE_ACQ;
    end
  endfunction

  function automatic cmre_pkg::out_item_t make_msg(input logic [1:0] kind, input id_t dest,
                                                   input logic cons, input amount_t amt,
                                                   input stamp_t stp);
    cmre_pkg::out_item_t m;
    m = '0;
    m.kind = kind;
    m.dest = dest;
    m.agree_consumed = cons;
    m.sent_amount = amt;
    m.sent_stamp = stp;
    return m;
  endfunction

  task automatic step_node(input cmre_pkg::in_item_t it);
    cmre_pkg::out_item_t msgs[$];
    cmre_pkg::out_item_t m;
    logic                dropped;
    logic                defer;
    dropped = 1'b0;
    case (it.func)
      cmre_pkg::FUNC_ACQUIRE: begin
        node_mode = cmre_pkg::MODE_COMP;
        permits = '0;
        my_stamp = it.stamp;
        msgs = {msgs, make_msg(cmre_pkg::KIND_REQUEST, '0, 1'b0, '0, my_stamp)};
      end
      cmre_pkg::FUNC_RELEASE: begin
        node_mode = cmre_pkg::MODE_IDLE;
        stock_level = sat_stock(stock_level - 1);
        for (int k = 0; k < waiting_count; k++)
          msgs = {msgs, make_msg(cmre_pkg::KIND_AGREE, waiting_ids[k], 1'b1, '0, '0)};
        waiting_count = 0;
        if (msgs.size() == 0) msgs = {msgs, make_msg(cmre_pkg::KIND_STATUS, '0, 1'b0, '0, '0)};
      end
      cmre_pkg::FUNC_REQUEST: begin
        if (node_mode == cmre_pkg::MODE_ACQ) begin
          defer = 1'b1;
        end else if (node_mode == cmre_pkg::MODE_COMP) begin
          defer = (it.stamp > my_stamp) || (it.stamp == my_stamp && it.sender > my_id);
        end else begin
          defer = 1'b0;
        end
        if (defer) begin
          if (waiting_count < QUEUE_DEPTH) begin
            waiting_ids[waiting_count] = it.sender;
            waiting_count++;
          end else begin
            dropped = 1'b1;
          end
          msgs = {msgs, make_msg(cmre_pkg::KIND_STATUS, '0, 1'b0, '0, '0)};
        end else begin
          msgs = {msgs, make_msg(cmre_pkg::KIND_AGREE, it.sender, 1'b0, '0, '0)};
        end
      end
      cmre_pkg::FUNC_AGREE: begin
        if (node_mode == cmre_pkg::MODE_COMP) begin
          if (it.consumed) stock_level = sat_stock(stock_level - 1);
          if (permits != '1) permits++;
          check_grant();
        end
        msgs = {msgs, make_msg(cmre_pkg::KIND_STATUS, '0, 1'b0, '0, '0)};
      end
      cmre_pkg::FUNC_INCREMENT: begin
        stock_level = sat_stock(stock_level + int'(it.amount));
        check_grant();
        msgs = {msgs, make_msg(cmre_pkg::KIND_STATUS, '0, 1'b0, '0, '0)};
      end
      cmre_pkg::FUNC_PRODUCE: begin
        msgs = {msgs, make_msg(cmre_pkg::KIND_INCR, '0, 1'b0, it.amount, my_stamp)};
        stock_level = sat_stock(stock_level + int'(it.amount));
        check_grant();
      end
      default: begin
        msgs = {msgs, make_msg(cmre_pkg::KIND_STATUS, '0, 1'b0, '0, '0)};
      end
    endcase
    foreach (msgs[k]) begin
      m = msgs[k];
      m.node_state = node_mode;
      m.resources = stock_level[cmre_pkg::STOCK_W-1:0];
      m.overflow = dropped;
      m.last = (k == msgs.size() - 1);
      due_msgs = {due_msgs, m};
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("%0t: mismatch: %s", $time, what);
  endtask

  task automatic queue_item(input func_t f, input stamp_t s, input id_t snd, input logic c,
                            input amount_t a);
    cmre_pkg::in_item_t it;
    it.func = f;
    it.stamp = s;
    it.sender = snd;
    it.consumed = c;
    it.amount = a;
    inbound = {inbound, it};
    queued_count++;
  endtask

  task automatic queue_rand(input func_t f, input stamp_t s);
    queue_item(f, s, id_t'($urandom_range(15)), 1'($urandom_range(1)),
               amount_t'($urandom_range(15)));
  endtask

  function automatic stamp_t pick_stamp();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2, 3: return stamp_t'($urandom_range(40));
      default: return stamp_t'($urandom);
    endcase
  endfunction

  function automatic stamp_t near_stamp(input stamp_t base);
    if ($urandom_range(4) == 0) return stamp_t'($urandom);
    return base + stamp_t'($urandom_range(2)) - stamp_t'(1);
  endfunction

  task automatic queue_supply();
    queue_rand($urandom_range(1) ? cmre_pkg::FUNC_PRODUCE : cmre_pkg::FUNC_INCREMENT,
               stamp_t'($urandom));
  endtask

  task automatic queue_round();
    stamp_t base;
    logic   late;
    int     n;
    base = pick_stamp();
    queue_rand(cmre_pkg::FUNC_ACQUIRE, base);
    repeat ($urandom_range(3)) queue_rand(cmre_pkg::FUNC_REQUEST, near_stamp(base));
    late = 1'($urandom_range(1));
    if (!late && $urandom_range(3) != 0) queue_supply();
    n = int'(peers);
    n = n + int'($urandom_range(2)) - 1;
    if ($urandom_range(7) == 0) n = n + 3;
    if (n < 0) n = 0;
    repeat (n) begin
      queue_item(cmre_pkg::FUNC_AGREE, stamp_t'($urandom), id_t'($urandom_range(15)),
                 ($urandom_range(3) == 0), amount_t'($urandom_range(15)));
      if ($urandom_range(5) == 0) queue_rand(cmre_pkg::FUNC_REQUEST, near_stamp(base));
    end
    if (late) queue_supply();
    if ($urandom_range(5) == 0)
      repeat ($urandom_range(14, 19))
        queue_rand(cmre_pkg::FUNC_REQUEST, base + stamp_t'($urandom_range(3)));
    queue_rand(cmre_pkg::FUNC_RELEASE, stamp_t'($urandom));
  endtask

  task automatic write_regs(input id_t id, input permit_t cnt);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= cmre_pkg::CFG_NODE_ID;
    cfg_wdata <= id;
    @(negedge clk);
    cfg_idx <= cmre_pkg::CFG_PEER_COUNT;
    cfg_wdata <= cnt;
    @(negedge clk);
    cfg_we <= 1'b0;
    my_id = id;
    peers = cnt;
  endtask

  task automatic set_idling(input int pattern);
    case (pattern)
      0: begin
        send_gap_pct = 6;
        recv_gap_pct = 84;
      end
      1: begin
        send_gap_pct = 84;
        recv_gap_pct = 6;
      end
      default: begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
    endcase
  endtask

  task automatic wait_drained();
    while (taken_count != queued_count || due_msgs.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin : drive_inbound
    logic send;
    if (rst_n && (!in_valid || in_taken)) begin
      send = (inbound.size() > 0) && ($urandom_range(99) >= send_gap_pct);
      if (send) in_data <= inbound.pop_front();
      in_valid <= send;
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(99) < recv_gap_pct);
  end

  always @(posedge clk) begin : watch_ports
    cmre_pkg::out_item_t want;
    if (rst_n) begin
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        step_node(in_data);
        taken_count++;
      end
      if (out_valid && !out_stall) begin
        if (due_msgs.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction 0x%0h", out_data));
        end else begin
          want = due_msgs.pop_front();
          if (out_data !== want) begin
            report_mismatch($sformatf("transaction got 0x%0h expected 0x%0h", out_data, want));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : run
    int n;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = cmre_pkg::CFG_NODE_ID;
    cfg_wdata = '0;
    in_taken = 1'b0;
    queued_count = 0;
    taken_count = 0;
    mismatches = 0;
    quiet_cycles = 0;
    my_id = '0;
    peers = 4'd1;
    node_mode = cmre_pkg::MODE_IDLE;
    permits = '0;
    my_stamp = '0;
    stock_level = 0;
    waiting_count = 0;
    set_idling(0);
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_regs(4'd5, 4'd2);
    queue_item(FUNC_SPARE_LO, 32'h0, 4'd0, 1'b0, 4'd0);
    queue_item(FUNC_SPARE_HI, '1, 4'd15, 1'b1, 4'd15);
    queue_item(cmre_pkg::FUNC_RELEASE, 32'h0, 4'd0, 1'b0, 4'd0);
    queue_item(cmre_pkg::FUNC_AGREE, 32'h0, 4'd3, 1'b1, 4'd0);
    queue_item(cmre_pkg::FUNC_PRODUCE, 32'h0, 4'd0, 1'b0, 4'd15);
    queue_item(cmre_pkg::FUNC_REQUEST, '1, 4'd15, 1'b0, 4'd0);
    queue_item(cmre_pkg::FUNC_ACQUIRE, 32'd100, 4'd0, 1'b0, 4'd0);
    queue_item(cmre_pkg::FUNC_REQUEST, 32'd101, 4'd3, 1'b0, 4'd0);
    queue_item(cmre_pkg::FUNC_REQUEST, 32'd100, 4'd9, 1'b0, 4'd0);
    queue_item(cmre_pkg::FUNC_REQUEST, 32'd100, 4'd2, 1'b0, 4'd0);
    queue_item(cmre_pkg::FUNC_REQUEST, 32'd99, 4'd0, 1'b0, 4'd0);
    queue_item(cmre_pkg::FUNC_REQUEST, 32'd100, 4'd5, 1'b0, 4'd0);
    queue_item(cmre_pkg::FUNC_AGREE, 32'h0, 4'd1, 1'b1, 4'd0);
    queue_item(cmre_pkg::FUNC_INCREMENT, 32'h0, 4'd1, 1'b0, 4'd0);
    queue_item(cmre_pkg::FUNC_AGREE, 32'h0, 4'd2, 1'b0, 4'd0);
    queue_item(cmre_pkg::FUNC_REQUEST, 32'h0, 4'd1, 1'b0, 4'd0);
    queue_item(cmre_pkg::FUNC_RELEASE, 32'h0, 4'd0, 1'b0, 4'd0);
    queue_item(cmre_pkg::FUNC_INCREMENT, 32'h0, 4'd0, 1'b0, 4'd15);
    queue_item(cmre_pkg::FUNC_ACQUIRE, '1, 4'd0, 1'b0, 4'd0);
    queue_item(cmre_pkg::FUNC_AGREE, 32'h0, 4'd8, 1'b0, 4'd0);
    queue_item(cmre_pkg::FUNC_AGREE, 32'h0, 4'd9, 1'b0, 4'd0);
    queue_item(cmre_pkg::FUNC_PRODUCE, 32'h0, 4'd0, 1'b0, 4'd0);
    queue_item(cmre_pkg::FUNC_RELEASE, 32'h0, 4'd0, 1'b0, 4'd0);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      set_idling(p / 2);
      case (p)
        0: write_regs(4'd0, 4'd0);
        1: write_regs(4'd15, 4'd15);
        2: write_regs(4'd0, 4'd15);
        3: write_regs(4'd15, 4'd0);
        4: write_regs(4'd10, 4'd1);
        default: write_regs(4'd3, 4'd4);
      endcase
      n = queued_count;
      while (queued_count - n < RANDOM_ITEMS) begin
        if ($urandom_range(5) == 0) queue_rand(func_t'($urandom_range(7)), stamp_t'($urandom));
        else queue_round();
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
